// ===== src/rlps_pkg.sv =====
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types, constants and helpers of the relativistic particle step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rlps_pkg;

    localparam int RLPS_VALUE_BITS = 48;
    localparam int RLPS_ID_BITS    = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELECTRIC_KICK = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAGNETIC_KICK = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_POS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WALL_HALF     = 3'd4;

    // Step status codes.
    localparam logic [1:0] ST_IN_FLIGHT = 2'd0;
    localparam logic [1:0] ST_SCREEN    = 2'd1;
    localparam logic [1:0] ST_WALL      = 2'd2;
    localparam logic [1:0] ST_NO_PART   = 2'd3;

    // Fixed-point constants.
    localparam logic [63:0] Q46_ONE     = 64'd70368744177664;
    localparam logic [63:0] BETA2_CLAMP = 64'd70368673808920;
    localparam logic [63:0] PROD_CAP    = 64'd4611686018427387904;
    localparam logic [63:0] GAMMA_ONE   = 64'd137438953472;

    // Gamma is floor(2^68 / s); s is at least 2^21, so 48 quotient bits suffice.
    localparam int Q_BITS    = 48;
    localparam int REM_BITS  = 34;
    localparam logic [REM_BITS-1:0] DIV_SEED = 34'd1048576;

    // Request to the shared multiplier: (a * b) rounded and shifted by 46 or 31.
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic               sh46;
        logic               neg;
    } t_mul_req;

    // Signed 64-bit add that saturates instead of wrapping.
    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            sadd64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sadd64 = s[63:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/rlps_mul.sv =====
// ----------------------------------------------------------------------------
// rlps_mul
// Shared signed multiplier: four 32x32 partial products, then a
// rounding shift with a magnitude cap of 2^62.
// ----------------------------------------------------------------------------
`default_nettype none

module rlps_mul
    import rlps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_mul_req           i_req,
    output logic                    o_done,
    output logic signed [63:0]      o_result
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic         r_done;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_sh46;
    logic         r_sign;
    logic [63:0]  r_pp;
    logic [1:0]   r_off;
    logic [127:0] r_acc;
    logic [63:0]  r_mag;
    logic signed [63:0] r_res;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [127:0] pp_shift;
    logic [128:0] rsum;
    logic [128:0] rq;
    logic [63:0]  a_mag;
    logic [63:0]  b_mag;

    assign a_mag = i_req.a[63] ? (64'd0 - 64'(i_req.a)) : 64'(i_req.a);
    assign b_mag = i_req.b[63] ? (64'd0 - 64'(i_req.b)) : 64'(i_req.b);
    assign pa    = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign pb    = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];

    always_comb begin
        unique case (r_off)
            2'd0:    pp_shift = {64'd0, r_pp};
            2'd1:    pp_shift = {32'd0, r_pp, 32'd0};
            2'd2:    pp_shift = {r_pp, 64'd0};
            default: pp_shift = 128'd0;
        endcase
    end

    always_comb begin
        if (r_sh46) begin
            rsum = {1'b0, r_acc} + (129'd1 << 45);
            rq   = rsum >> 46;
        end else begin
            rsum = {1'b0, r_acc} + (129'd1 << 30);
            rq   = rsum >> 31;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_ua   <= a_mag;
                r_ub   <= b_mag;
                r_sh46 <= i_req.sh46;
                r_sign <= i_req.a[63] ^ i_req.b[63] ^ i_req.neg;
                r_acc  <= 128'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt <= 3'd3) begin
                    r_pp  <= 64'(pa) * 64'(pb);
                    r_off <= 2'(r_cnt[1]) + 2'(r_cnt[0]);
                end
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    r_acc <= r_acc + pp_shift;
                end
                if (r_cnt == 3'd5) begin
                    r_mag <= (rq > 129'(PROD_CAP)) ? PROD_CAP : rq[63:0];
                end
                if (r_cnt == 3'd6) begin
                    r_res  <= r_sign ? (64'sd0 - signed'(r_mag)) : signed'(r_mag);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== src/relativistic_lorentz_particle_step_unit.sv =====
// ----------------------------------------------------------------------------
// relativistic_lorentz_particle_step_unit
// Euler push of one charged particle through crossed Ey and Bz fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries load and step beats. A
//   load beat starts a particle and yields no result. A step beat yields
//   one result beat on the output channel (o_out_valid / i_out_ready).
//   A step of a live particle runs two multiplies for beta squared, 32 root
//   iterations, 48 divider iterations for gamma and six more multiplies, all
//   on the one shared 32x32 multiplier. A step with the particle already at
//   the screen finishes after the root and divide; a step without a particle
//   skips the arithmetic and goes from idle straight to the output.
//   o_in_ready is high only while the sequencer is idle. The result sits in an
//   output register, so the next beat is accepted and worked on while it
//   waits; only the final write of the next result waits for the receiver.
//   Configuration writes (i_cfg_we) take effect at once and must be made while
//   the block is idle. Synchronous reset clears the particle, the registers to
//   their defaults and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module relativistic_lorentz_particle_step_unit
    import rlps_pkg::*;
#(
    parameter int VALUE_BITS = RLPS_VALUE_BITS,
    parameter int ID_BITS    = RLPS_ID_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire logic [VALUE_BITS-1:0]         i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_req_type,
    input  wire logic [VALUE_BITS-3:0]         i_start_beta_x,
    input  wire logic signed [VALUE_BITS-1:0]  i_start_y,
    input  wire logic signed [VALUE_BITS-1:0]  i_start_z,
    input  wire logic                          i_negative_charge,
    input  wire logic [ID_BITS-1:0]            i_start_id,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ID_BITS-1:0]                 o_particle_number,
    output logic signed [VALUE_BITS-1:0]       o_pos_x,
    output logic signed [VALUE_BITS-1:0]       o_pos_y,
    output logic signed [VALUE_BITS-1:0]       o_pos_z,
    output logic [VALUE_BITS-2:0]              o_lorentz_gamma,
    output logic                               o_charge_is_negative,
    output logic [1:0]                         o_step_status
);

    localparam int W = VALUE_BITS;
    localparam logic signed [63:0] V_MAX = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] V_MIN = -V_MAX - 64'sd1;
    localparam logic [W-2:0] STEP_RST   = (W-1)'(1055);
    localparam logic [W-2:0] SCREEN_RST = (W-1)'(64'd35184372088832);
    localparam logic [W-2:0] WALL_RST   = (W-1)'(64'd17592186044416);
    localparam int CNT_BITS = $clog2(Q_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MXX, S_MYY, S_SQRT, S_DIV, S_CHK, S_MAX, S_MAY,
        S_MDBX, S_MDBY, S_MX, S_MY, S_FIN, S_OUT
    } t_state;

    function automatic logic signed [63:0] sat_val(input logic signed [63:0] v);
        if (v > V_MAX) begin
            sat_val = V_MAX;
        end else if (v < V_MIN) begin
            sat_val = V_MIN;
        end else begin
            sat_val = v;
        end
    endfunction

    t_state r_state;

    // Configuration.
    logic signed [W-1:0] r_ek;
    logic signed [W-1:0] r_mk;
    logic [W-2:0]        r_step_len;
    logic [W-2:0]        r_screen;
    logic [W-2:0]        r_wall;

    // Particle.
    logic                r_in_flight;
    logic signed [W-1:0] r_bx;
    logic signed [W-1:0] r_by;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic                r_sign;
    logic [ID_BITS-1:0]  r_id;

    // Work registers.
    logic [63:0]         r_t;
    logic [63:0]         r_v;
    logic [63:0]         r_res;
    logic [63:0]         r_bit;
    logic [REM_BITS-1:0] r_rem;
    logic [Q_BITS-1:0]   r_q;
    logic [CNT_BITS-1:0] r_cnt;
    logic signed [63:0]  r_ax;
    logic signed [63:0]  r_ay;
    logic [1:0]          r_status;
    logic                r_no_part;
    logic                r_mul_start;

    // Output register.
    logic                r_out_valid;
    logic [ID_BITS-1:0]  r_o_id;
    logic signed [W-1:0] r_o_x;
    logic signed [W-1:0] r_o_y;
    logic signed [W-1:0] r_o_z;
    logic [W-2:0]        r_o_gamma;
    logic                r_o_neg;
    logic [1:0]          r_o_status;

    t_mul_req           mul_req;
    logic               mul_done;
    logic signed [63:0] mul_res;

    logic [63:0]         b2;
    logic [63:0]         b2c;
    logic [63:0]         sq_trial;
    logic [REM_BITS-1:0] dv_t;
    logic signed [63:0]  new_v;
    logic [63:0]         y_mag;
    logic [63:0]         q64;
    logic                in_acc;
    logic                out_free;

    rlps_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // Operand selection follows the state; the multiplier latches on start.
    always_comb begin
        mul_req.start = r_mul_start;
        mul_req.sh46  = 1'b1;
        mul_req.neg   = 1'b0;
        mul_req.a     = 64'(r_bx);
        mul_req.b     = 64'(r_bx);
        unique case (r_state)
            S_MXX: begin
                mul_req.a = 64'(r_bx);
                mul_req.b = 64'(r_bx);
            end
            S_MYY: begin
                mul_req.a = 64'(r_by);
                mul_req.b = 64'(r_by);
            end
            S_MAX: begin
                mul_req.a = 64'(r_mk);
                mul_req.b = 64'(r_by);
            end
            S_MAY: begin
                mul_req.a = 64'(r_mk);
                mul_req.b = 64'(r_bx);
            end
            S_MDBX: begin
                mul_req.a    = r_ax;
                mul_req.b    = signed'(r_res);
                mul_req.sh46 = 1'b0;
                mul_req.neg  = r_sign;
            end
            S_MDBY: begin
                mul_req.a    = r_ay;
                mul_req.b    = signed'(r_res);
                mul_req.sh46 = 1'b0;
                mul_req.neg  = r_sign;
            end
            S_MX: begin
                mul_req.a = 64'(r_bx);
                mul_req.b = signed'(64'(r_step_len));
            end
            S_MY: begin
                mul_req.a = 64'(r_by);
                mul_req.b = signed'(64'(r_step_len));
            end
            default: begin
                mul_req.a = 64'(r_bx);
                mul_req.b = 64'(r_bx);
            end
        endcase
    end

    assign b2       = r_t + 64'(mul_res);
    assign b2c      = (b2 > BETA2_CLAMP) ? BETA2_CLAMP : b2;
    assign sq_trial = r_res + r_bit;
    assign dv_t     = {r_rem[REM_BITS-2:0], 1'b0};
    assign y_mag    = r_y[W-1] ? (64'd0 - 64'(r_y)) : 64'(r_y);
    assign q64      = 64'(r_q);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (r_state)
            S_MDBX:  new_v = sat_val(sadd64(64'(r_bx), mul_res));
            S_MDBY:  new_v = sat_val(sadd64(64'(r_by), mul_res));
            S_MX:    new_v = sat_val(sadd64(64'(r_x), mul_res));
            default: new_v = sat_val(sadd64(64'(r_y), mul_res));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ek        <= '0;
            r_mk        <= '0;
            r_step_len  <= STEP_RST;
            r_screen    <= SCREEN_RST;
            r_wall      <= WALL_RST;
            r_in_flight <= 1'b0;
            r_bx        <= '0;
            r_by        <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= '0;
            r_sign      <= 1'b0;
            r_id        <= '0;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ELECTRIC_KICK: r_ek       <= signed'(i_cfg_data);
                    CFG_MAGNETIC_KICK: r_mk       <= signed'(i_cfg_data);
                    CFG_STEP_LENGTH:   r_step_len <= i_cfg_data[W-2:0];
                    CFG_SCREEN_POS:    r_screen   <= i_cfg_data[W-2:0];
                    CFG_WALL_HALF:     r_wall     <= i_cfg_data[W-2:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        priority if (!i_req_type) begin
                            r_in_flight <= 1'b1;
                            r_bx        <= signed'(W'(i_start_beta_x));
                            r_by        <= '0;
                            r_x         <= '0;
                            r_y         <= i_start_y;
                            r_z         <= i_start_z;
                            r_sign      <= i_negative_charge;
                            r_id        <= i_start_id;
                        end else if (!r_in_flight) begin
                            r_no_part <= 1'b1;
                            r_status  <= ST_NO_PART;
                            r_state   <= S_OUT;
                        end else begin
                            r_no_part   <= 1'b0;
                            r_mul_start <= 1'b1;
                            r_state     <= S_MXX;
                        end
                    end
                end
                S_MXX: begin
                    if (mul_done) begin
                        r_t         <= 64'(mul_res);
                        r_mul_start <= 1'b1;
                        r_state     <= S_MYY;
                    end
                end
                S_MYY: begin
                    if (mul_done) begin
                        r_v     <= (Q46_ONE - b2c) << 16;
                        r_res   <= 64'd0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // One result bit per cycle of the digit-by-digit root.
                    if (r_v >= sq_trial) begin
                        r_v   <= r_v - sq_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_rem   <= DIV_SEED;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (dv_t >= REM_BITS'(r_res)) begin
                        r_rem <= dv_t - REM_BITS'(r_res);
                        r_q   <= {r_q[Q_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= dv_t;
                        r_q   <= {r_q[Q_BITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_BITS'(1);
                    if (r_cnt == CNT_BITS'(Q_BITS - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // A particle already at the screen is not pushed.
                    if (r_x >= signed'({1'b0, r_screen})) begin
                        r_status    <= ST_SCREEN;
                        r_in_flight <= 1'b0;
                        r_state     <= S_OUT;
                    end else begin
                        r_mul_start <= 1'b1;
                        r_state     <= S_MAX;
                    end
                end
                S_MAX: begin
                    if (mul_done) begin
                        r_ax        <= mul_res;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MAY;
                    end
                end
                S_MAY: begin
                    if (mul_done) begin
                        r_ay        <= sadd64(64'(r_ek), 64'sd0 - mul_res);
                        r_mul_start <= 1'b1;
                        r_state     <= S_MDBX;
                    end
                end
                S_MDBX: begin
                    if (mul_done) begin
                        r_bx        <= new_v[W-1:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_MDBY;
                    end
                end
                S_MDBY: begin
                    if (mul_done) begin
                        r_by        <= new_v[W-1:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_MX;
                    end
                end
                S_MX: begin
                    if (mul_done) begin
                        r_x         <= new_v[W-1:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_MY;
                    end
                end
                S_MY: begin
                    if (mul_done) begin
                        r_y     <= new_v[W-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    priority if (y_mag > 64'(r_wall)) begin
                        r_status    <= ST_WALL;
                        r_in_flight <= 1'b0;
                    end else if (r_x >= signed'({1'b0, r_screen})) begin
                        r_status    <= ST_SCREEN;
                        r_in_flight <= 1'b0;
                    end else begin
                        r_status <= ST_IN_FLIGHT;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        if (r_no_part) begin
                            r_o_id    <= '0;
                            r_o_x     <= '0;
                            r_o_y     <= '0;
                            r_o_z     <= '0;
                            r_o_gamma <= '0;
                            r_o_neg   <= 1'b0;
                        end else begin
                            r_o_id    <= r_id;
                            r_o_x     <= r_x;
                            r_o_y     <= r_y;
                            r_o_z     <= r_z;
                            r_o_gamma <= q64[W-2:0];
                            r_o_neg   <= r_sign;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_particle_number    = r_o_id;
    assign o_pos_x              = r_o_x;
    assign o_pos_y              = r_o_y;
    assign o_pos_z              = r_o_z;
    assign o_lorentz_gamma      = r_o_gamma;
    assign o_charge_is_negative = r_o_neg;
    assign o_step_status        = r_o_status;

    // A particle only ends after the screen check or the final status decision.
    a_flight_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_in_flight) |-> ($past(r_state) == S_CHK || $past(r_state) == S_FIN))
        else $error("particle ended outside a step");

    // The root never reaches zero, so the divider always has a nonzero divisor.
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_res != 64'd0))
        else $error("zero divisor in gamma divide");

    // Gamma is never below one.
    a_gamma_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (64'(r_q) >= GAMMA_ONE))
        else $error("gamma below one");

    // The multiplier reports only while a multiply state waits for it.
    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MXX || r_state == S_MYY || r_state == S_MAX ||
                      r_state == S_MAY || r_state == S_MDBX || r_state == S_MDBY ||
                      r_state == S_MX || r_state == S_MY))
        else $error("multiplier result with no consumer");

endmodule

`default_nettype wire
